/* rtl/mlps_pkg.sv */
// Shared types, constants and register codes for the multi-lane LED pulse serializer.
package mlps_pkg;

    // Lane count default and fixed byte lanes carried by one word
    localparam int LANES_DEF   = 8;
    localparam int BYTE_LANES  = 8;

    // Slave word layout (tdata), lowest bit first
    localparam int RED_LSB     = 0;
    localparam int GREEN_LSB   = 64;
    localparam int BLUE_LSB    = 128;
    localparam int WHITE_LSB   = 192;
    localparam int PRES_LSB    = 256;
    localparam int S_TDATA_W   = 264;
    localparam int S_TUSER_W   = 2;

    // Master word layout: pins, busy, rejected, zero pad
    localparam int M_TDATA_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LANE_COUNT   = 3'd0,
        REG_FOUR_CHANNEL = 3'd1,
        REG_INVERT       = 3'd2,
        REG_LEAD_SLOTS   = 3'd3,
        REG_DATA_SLOTS   = 3'd4,
        REG_TAIL_SLOTS   = 3'd5,
        REG_RESET_SLOTS  = 3'd6
    } t_reg_idx;

    // Reset values of the configuration registers
    localparam logic [3:0]  RST_LANE_COUNT  = 4'd1;
    localparam logic [7:0]  RST_LEAD_SLOTS  = 8'd3;
    localparam logic [7:0]  RST_DATA_SLOTS  = 8'd9;
    localparam logic [7:0]  RST_TAIL_SLOTS  = 8'd4;
    localparam logic [15:0] RST_RESET_SLOTS = 16'd1000;

    // Bits sent per pixel
    localparam logic [5:0]  BITS_RGB  = 6'd24;
    localparam logic [5:0]  BITS_RGBW = 6'd32;

    // Word kinds (tuser)
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_START = 2'd2
    } t_mode;

    // Sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_GAP  = 5'b00010,
        PH_LEAD = 5'b00100,
        PH_DATA = 5'b01000,
        PH_TAIL = 5'b10000
    } t_phase;

    // Timing configuration seen by the sequencer
    typedef struct packed {
        logic        four_channel;
        logic [7:0]  lead_slots;
        logic [7:0]  data_slots;
        logic [7:0]  tail_slots;
        logic [15:0] reset_slots;
    } t_cfg;

    // Per-word commands from the sequencer to the lanes and pin merge
    typedef struct packed {
        logic load;
        logic shift;
        logic drive_all;
        logic drive_data;
        logic rejected;
        logic busy;
    } t_ctrl;

endpackage

/* rtl/multi_lane_led_pulse_serializer_top.sv */
// Top level: config registers, lanes, pin merge and output skid buffer.
// A result word is registered in the head, or in the skid register if the head is full.
// Throughput: one word per cycle while the skid register is empty; the two-entry buffer
// keeps s_axis_tready high while one result waits and drops it while two results wait.
// Reset (i_rst_n low, synchronous): sequencer idle, lanes cleared, output buffer
// empty, configuration back to lane_count 1, RGB, not inverted, slots 3/9/4/1000.
module multi_lane_led_pulse_serializer_top #(
    parameter int LANES = mlps_pkg::LANES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: red_bytes, green_bytes, blue_bytes, white_bytes, lane_present
    input  logic [mlps_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: mode
    input  logic [mlps_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // Master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: lane_pins, busy_res, load_rejected, zero pad
    output logic [mlps_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [mlps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mlps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int BYTE_LANES = (LANES < mlps_pkg::BYTE_LANES) ? LANES
                                                                : mlps_pkg::BYTE_LANES;
    localparam logic [3:0] BYTE_LANES_W = 4'(BYTE_LANES);

    // Configuration registers
    logic [3:0]  r_lane_count;
    logic        r_four_ch;
    logic        r_invert;
    logic [7:0]  r_lead, r_data, r_tail;
    logic [15:0] r_reset_slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_count  <= mlps_pkg::RST_LANE_COUNT;
            r_four_ch     <= 1'b0;
            r_invert      <= 1'b0;
            r_lead        <= mlps_pkg::RST_LEAD_SLOTS;
            r_data        <= mlps_pkg::RST_DATA_SLOTS;
            r_tail        <= mlps_pkg::RST_TAIL_SLOTS;
            r_reset_slots <= mlps_pkg::RST_RESET_SLOTS;
        end else if (i_cfg_we) begin
            case (mlps_pkg::t_reg_idx'(i_cfg_idx))
                mlps_pkg::REG_LANE_COUNT:   r_lane_count  <= i_cfg_data[3:0];
                mlps_pkg::REG_FOUR_CHANNEL: r_four_ch     <= i_cfg_data[0];
                mlps_pkg::REG_INVERT:       r_invert      <= i_cfg_data[0];
                mlps_pkg::REG_LEAD_SLOTS:   r_lead        <= i_cfg_data[7:0];
                mlps_pkg::REG_DATA_SLOTS:   r_data        <= i_cfg_data[7:0];
                mlps_pkg::REG_TAIL_SLOTS:   r_tail        <= i_cfg_data[7:0];
                mlps_pkg::REG_RESET_SLOTS:  r_reset_slots <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake and sequencer
    logic             r_ov, r_sv;
    logic [9:0]       r_od, r_sd;
    logic             w_accept, w_pop;
    mlps_pkg::t_cfg   w_cfg;
    mlps_pkg::t_ctrl  w_ctrl;

    assign s_axis_tready = !r_sv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pop         = r_ov && m_axis_tready;

    assign w_cfg.four_channel = r_four_ch;
    assign w_cfg.lead_slots   = r_lead;
    assign w_cfg.data_slots   = r_data;
    assign w_cfg.tail_slots   = r_tail;
    assign w_cfg.reset_slots  = r_reset_slots;

    mlps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_mode   (mlps_pkg::t_mode'(s_axis_tuser)),
        .i_cfg    (w_cfg),
        .o_ctrl   (w_ctrl)
    );

    // Lanes; only the first eight carry bytes, the rest load zero
    logic [LANES-1:0] w_lane_bit;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [7:0] w_g, w_r, w_b, w_w;
        logic       w_p;
        if (k < mlps_pkg::BYTE_LANES) begin : g_byte
            assign w_r = s_axis_tdata[mlps_pkg::RED_LSB   + 8*k +: 8];
            assign w_g = s_axis_tdata[mlps_pkg::GREEN_LSB + 8*k +: 8];
            assign w_b = s_axis_tdata[mlps_pkg::BLUE_LSB  + 8*k +: 8];
            assign w_w = s_axis_tdata[mlps_pkg::WHITE_LSB + 8*k +: 8];
            assign w_p = s_axis_tdata[mlps_pkg::PRES_LSB  + k];
        end else begin : g_zero
            assign w_r = 8'd0;
            assign w_g = 8'd0;
            assign w_b = 8'd0;
            assign w_w = 8'd0;
            assign w_p = 1'b0;
        end
        mlps_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (w_ctrl.load),
            .i_shift   (w_ctrl.shift),
            .i_four_ch (r_four_ch),
            .i_green   (w_g),
            .i_red     (w_r),
            .i_blue    (w_b),
            .i_white   (w_w),
            .i_present (w_p),
            .o_bit     (w_lane_bit[k])
        );
    end

    // Merge: data-active bits of the byte lanes
    logic [7:0] w_data_act;

    for (genvar k = 0; k < 8; k++) begin : g_merge
        if (k < LANES) begin : g_on
            assign w_data_act[k] = w_lane_bit[k];
        end else begin : g_off
            assign w_data_act[k] = 1'b0;
        end
    end

    // Enabled lanes and pin levels
    logic [3:0] w_n_lanes;
    logic [7:0] w_en, w_act, w_pins;
    logic [9:0] w_result;

    assign w_n_lanes = (r_lane_count > BYTE_LANES_W) ? BYTE_LANES_W : r_lane_count;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_en[k] = 4'(k) < w_n_lanes;
        end
    end

    assign w_act    = (w_ctrl.drive_all ? 8'hFF : (w_ctrl.drive_data ? w_data_act : 8'd0))
                      & w_en;
    assign w_pins   = r_invert ? (w_en & ~w_act) : w_act;
    assign w_result = {w_ctrl.rejected, w_ctrl.busy, w_pins};

    // Two-entry output buffer: head register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_pop) begin
            if (r_sv) begin
                r_sv <= 1'b0;
            end else if (!w_accept) begin
                r_ov <= 1'b0;
            end
        end else if (w_accept) begin
            if (r_ov) r_sv <= 1'b1;
            else      r_ov <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_sv)          r_od <= r_sd;
            else if (w_accept) r_od <= w_result;
        end else if (w_accept) begin
            if (r_ov) r_sd <= w_result;
            else      r_od <= w_result;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(mlps_pkg::M_TDATA_W - 10){1'b0}}, r_od};

    // Checks
    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid word held with empty head");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_ov) else $error("accepted word produced no result");

    a_load_shift_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.load && w_ctrl.shift)) else $error("load and shift together");

    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.drive_all && w_ctrl.drive_data)) else $error("two drive sources");

endmodule

/* rtl/mlps_lane.sv */
// One lane: 32-bit pixel shift register and present flag.
module mlps_lane (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_shift,
    input  logic       i_four_ch,
    input  logic [7:0] i_green,
    input  logic [7:0] i_red,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_white,
    input  logic       i_present,
    output logic       o_bit
);

    logic [31:0] r_shift;
    logic        r_present;

    // Load GRB(W), msb first out; shift after each bit's tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= '0;
            r_present <= 1'b0;
        end else if (i_load) begin
            r_shift   <= {i_green, i_red, i_blue, (i_four_ch ? i_white : 8'd0)};
            r_present <= i_present;
        end else if (i_shift) begin
            r_shift   <= {r_shift[30:0], 1'b0};
        end
    end

    assign o_bit = r_present & r_shift[31];

endmodule

/* rtl/mlps_ctrl.sv */
// Bit timing sequencer: phase, slot counter and bits remaining.
module mlps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  mlps_pkg::t_mode      i_mode,
    input  mlps_pkg::t_cfg       i_cfg,
    output mlps_pkg::t_ctrl      o_ctrl
);

    mlps_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_cnt, n_cnt;
    logic [5:0]       r_bits, n_bits;

    logic [15:0] w_len;
    logic [16:0] w_cnt_inc;
    logic        w_done;
    logic [5:0]  w_bits_dec;
    logic        w_busy;

    // Length of the current phase; zero acts as one through the >= test
    always_comb begin
        case (r_phase)
            mlps_pkg::PH_GAP:  w_len = i_cfg.reset_slots;
            mlps_pkg::PH_LEAD: w_len = {8'd0, i_cfg.lead_slots};
            mlps_pkg::PH_DATA: w_len = {8'd0, i_cfg.data_slots};
            mlps_pkg::PH_TAIL: w_len = {8'd0, i_cfg.tail_slots};
            default:           w_len = 16'd0;
        endcase
    end

    assign w_cnt_inc  = {1'b0, r_cnt} + 17'd1;
    assign w_done     = w_cnt_inc >= {1'b0, w_len};
    assign w_bits_dec = (r_bits != 6'd0) ? r_bits - 6'd1 : 6'd0;
    assign w_busy     = r_phase != mlps_pkg::PH_IDLE;

    // Next state and commands for the accepted word
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_bits  = r_bits;
        o_ctrl  = '0;
        if (i_accept) begin
            case (i_mode)
                mlps_pkg::MODE_TICK: begin
                    if (w_busy) begin
                        n_cnt = w_done ? 16'd0 : w_cnt_inc[15:0];
                    end
                    case (r_phase)
                        mlps_pkg::PH_GAP: begin
                            if (w_done) n_phase = mlps_pkg::PH_IDLE;
                        end
                        mlps_pkg::PH_LEAD: begin
                            o_ctrl.drive_all = 1'b1;
                            if (w_done) n_phase = mlps_pkg::PH_DATA;
                        end
                        mlps_pkg::PH_DATA: begin
                            o_ctrl.drive_data = 1'b1;
                            if (w_done) n_phase = mlps_pkg::PH_TAIL;
                        end
                        mlps_pkg::PH_TAIL: begin
                            if (w_done) begin
                                o_ctrl.shift = 1'b1;
                                n_bits  = w_bits_dec;
                                n_phase = (w_bits_dec != 6'd0) ? mlps_pkg::PH_LEAD
                                                               : mlps_pkg::PH_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                mlps_pkg::MODE_LOAD: begin
                    if (w_busy) begin
                        o_ctrl.rejected = 1'b1;
                    end else begin
                        o_ctrl.load = 1'b1;
                        n_bits  = i_cfg.four_channel ? mlps_pkg::BITS_RGBW
                                                     : mlps_pkg::BITS_RGB;
                        n_cnt   = 16'd0;
                        n_phase = mlps_pkg::PH_LEAD;
                    end
                end
                mlps_pkg::MODE_START: begin
                    if (w_busy) begin
                        o_ctrl.rejected = 1'b1;
                    end else begin
                        n_cnt   = 16'd0;
                        n_phase = mlps_pkg::PH_GAP;
                    end
                end
                default: begin
                end
            endcase
        end
        o_ctrl.busy = n_phase != mlps_pkg::PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mlps_pkg::PH_IDLE;
            r_cnt   <= '0;
            r_bits  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
        end
    end

endmodule

/* sim/multi_lane_led_pulse_serializer_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the multi-lane LED pulse serializer top level.
module multi_lane_led_pulse_serializer_top_test;

    localparam logic [1:0]                     MODE_UNUSED = 2'd3;
    localparam logic [mlps_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam int LONG_HOLD     = 300;    // receiver hold-off for the backpressure test
    localparam int DRAIN_LIMIT   = 200000; // cycles allowed for outstanding words
    localparam int SETTINGS_N    = 8;      // timing settings in the random sweep
    localparam int SWEEP_WORDS   = 64;     // random words per setting
    localparam int GAP_TICKS     = 64;     // ticks into the reset-value gap
    localparam int EXTREME_TICKS = 270;    // ticks into a long gap or a long lead part

    // One result word as predicted
    typedef struct packed {
        logic [7:0] pins;
        logic       busy;
        logic       rejected;
    } t_pin_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // tdata: red_bytes, green_bytes, blue_bytes, white_bytes, lane_present
    logic [mlps_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    // tuser: mode
    logic [mlps_pkg::S_TUSER_W-1:0]  s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // tdata: lane_pins, busy_res, load_rejected, zero pad
    logic [mlps_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            i_cfg_we;
    logic [mlps_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [mlps_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Serializer state as predicted
    logic [31:0]      lane_bits [8];
    logic [7:0]       pres_mask;
    logic [5:0]       bits_due;
    mlps_pkg::t_phase seq_phase;
    logic [15:0]      slot_cnt;

    // Register copies
    logic [3:0]  cfg_lanes;
    logic        cfg_four;
    logic        cfg_inv;
    logic [7:0]  cfg_lead;
    logic [7:0]  cfg_data;
    logic [7:0]  cfg_tail;
    logic [15:0] cfg_gap;

    t_pin_word pin_words_due [$];

    int errors = 0;
    int words_checked = 0;
    int pixels_loaded = 0;
    int gaps_started = 0;
    int refused_cnt = 0;
    int input_stall_cycles = 0;
    int stall_requests = 0;
    int stall_served = 0;
    bit src_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;

    multi_lane_led_pulse_serializer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_serializer();
        int k;
        for (k = 0; k < 8; k++) lane_bits[k] = '0;
        pres_mask = '0;
        bits_due  = '0;
        seq_phase = mlps_pkg::PH_IDLE;
        slot_cnt  = '0;
        cfg_lanes = mlps_pkg::RST_LANE_COUNT;
        cfg_four  = 1'b0;
        cfg_inv   = 1'b0;
        cfg_lead  = mlps_pkg::RST_LEAD_SLOTS;
        cfg_data  = mlps_pkg::RST_DATA_SLOTS;
        cfg_tail  = mlps_pkg::RST_TAIL_SLOTS;
        cfg_gap   = mlps_pkg::RST_RESET_SLOTS;
    endfunction

    function automatic void apply_reg(input logic [mlps_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [mlps_pkg::CFG_DATA_W-1:0] v);
        case (idx)
            mlps_pkg::REG_LANE_COUNT:   cfg_lanes = v[3:0];
            mlps_pkg::REG_FOUR_CHANNEL: cfg_four  = v[0];
            mlps_pkg::REG_INVERT:       cfg_inv   = v[0];
            mlps_pkg::REG_LEAD_SLOTS:   cfg_lead  = v[7:0];
            mlps_pkg::REG_DATA_SLOTS:   cfg_data  = v[7:0];
            mlps_pkg::REG_TAIL_SLOTS:   cfg_tail  = v[7:0];
            mlps_pkg::REG_RESET_SLOTS:  cfg_gap   = v;
            default: ;
        endcase
    endfunction

    // Lanes below the lane count; counts above eight saturate
    function automatic logic [7:0] lane_enable_mask();
        logic [7:0] m;
        int k;
        m = '0;
        for (k = 0; k < 8; k++) m[k] = (k < cfg_lanes);
        return m;
    endfunction

    function automatic logic [7:0] drive_levels(input logic [7:0] active);
        logic [7:0] en;
        logic [7:0] a;
        en = lane_enable_mask();
        a  = active & en;
        return cfg_inv ? (en & ~a) : a;
    endfunction

    function automatic logic [7:0] data_lanes();
        logic [7:0] m;
        int k;
        for (k = 0; k < 8; k++) m[k] = pres_mask[k] & lane_bits[k][31];
        return m;
    endfunction

    // One slot of the current part; a length of zero behaves as one
    function automatic logic part_done(input logic [15:0] len);
        if ({1'b0, slot_cnt} + 17'd1 >= {1'b0, len}) begin
            slot_cnt = '0;
            return 1'b1;
        end
        slot_cnt = slot_cnt + 16'd1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] tick_slot();
        logic [7:0] pins;
        int k;
        case (seq_phase)
            mlps_pkg::PH_GAP: begin
                pins = drive_levels(8'h00);
                if (part_done(cfg_gap)) seq_phase = mlps_pkg::PH_IDLE;
            end
            mlps_pkg::PH_LEAD: begin
                pins = drive_levels(8'hFF);
                if (part_done({8'd0, cfg_lead})) seq_phase = mlps_pkg::PH_DATA;
            end
            mlps_pkg::PH_DATA: begin
                pins = drive_levels(data_lanes());
                if (part_done({8'd0, cfg_data})) seq_phase = mlps_pkg::PH_TAIL;
            end
            mlps_pkg::PH_TAIL: begin
                pins = drive_levels(8'h00);
                if (part_done({8'd0, cfg_tail})) begin
                    for (k = 0; k < 8; k++) lane_bits[k] = lane_bits[k] << 1;
                    if (bits_due != 0) bits_due = bits_due - 6'd1;
                    seq_phase = (bits_due != 0) ? mlps_pkg::PH_LEAD : mlps_pkg::PH_IDLE;
                end
            end
            default: pins = drive_levels(8'h00);
        endcase
        return pins;
    endfunction

    // Advance the prediction by one accepted word and queue its result
    function automatic void serialize_word(input logic [1:0] mode,
                                           input logic [mlps_pkg::S_TDATA_W-1:0] d);
        t_pin_word w;
        logic busy_now;
        int k;
        w.rejected = 1'b0;
        busy_now = (seq_phase != mlps_pkg::PH_IDLE);
        if (mode == mlps_pkg::MODE_TICK) begin
            w.pins = tick_slot();
        end else begin
            if (mode == mlps_pkg::MODE_LOAD || mode == mlps_pkg::MODE_START) begin
                if (busy_now) begin
                    w.rejected = 1'b1;
                    refused_cnt++;
                end else if (mode == mlps_pkg::MODE_LOAD) begin
                    for (k = 0; k < 8; k++)
                        lane_bits[k] = {d[mlps_pkg::GREEN_LSB + 8*k +: 8],
                                        d[mlps_pkg::RED_LSB + 8*k +: 8],
                                        d[mlps_pkg::BLUE_LSB + 8*k +: 8],
                                        cfg_four ? d[mlps_pkg::WHITE_LSB + 8*k +: 8]
                                                 : 8'h00};
                    pres_mask = d[mlps_pkg::PRES_LSB +: 8];
                    bits_due  = cfg_four ? mlps_pkg::BITS_RGBW : mlps_pkg::BITS_RGB;
                    slot_cnt  = '0;
                    seq_phase = mlps_pkg::PH_LEAD;
                    pixels_loaded++;
                end else begin
                    slot_cnt  = '0;
                    seq_phase = mlps_pkg::PH_GAP;
                    gaps_started++;
                end
            end
            w.pins = drive_levels(8'h00);
        end
        w.busy = (seq_phase != mlps_pkg::PH_IDLE);
        pin_words_due.push_back(w);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [mlps_pkg::S_TDATA_W-1:0] pack_pixel(input logic [63:0] red,
        input logic [63:0] green, input logic [63:0] blue, input logic [63:0] white,
        input logic [7:0] present);
        logic [mlps_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[mlps_pkg::RED_LSB   +: 64] = red;
        d[mlps_pkg::GREEN_LSB +: 64] = green;
        d[mlps_pkg::BLUE_LSB  +: 64] = blue;
        d[mlps_pkg::WHITE_LSB +: 64] = white;
        d[mlps_pkg::PRES_LSB  +: 8]  = present;
        return d;
    endfunction

    function automatic logic [mlps_pkg::S_TDATA_W-1:0] rand_pixel();
        logic [7:0] present;
        present = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
        return pack_pixel(rand64(), rand64(), rand64(), rand64(), present);
    endfunction

    // Mostly complete pixels and gaps; some refused commands and unused codes
    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (seq_phase == mlps_pkg::PH_IDLE) begin
            if (r < 50) return mlps_pkg::MODE_LOAD;
            if (r < 75) return mlps_pkg::MODE_START;
            if (r < 88) return mlps_pkg::MODE_TICK;
            return MODE_UNUSED;
        end
        if (r < 90) return mlps_pkg::MODE_TICK;
        if (r < 95) return mlps_pkg::MODE_LOAD;
        if (r < 98) return mlps_pkg::MODE_START;
        return MODE_UNUSED;
    endfunction

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] mode,
                             input logic [mlps_pkg::S_TDATA_W-1:0] d);
        int gap;
        gap = (src_gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = d;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        serialize_word(mode, d);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mlps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mlps_pkg::CFG_DATA_W-1:0] v);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = v;
        @(posedge i_clk);
        apply_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] lanes, input logic [15:0] four,
        input logic [15:0] inv, input logic [15:0] lead, input logic [15:0] dat,
        input logic [15:0] tail, input logic [15:0] gap);
        write_reg(mlps_pkg::REG_LANE_COUNT, lanes);
        write_reg(mlps_pkg::REG_FOUR_CHANNEL, four);
        write_reg(mlps_pkg::REG_INVERT, inv);
        write_reg(mlps_pkg::REG_LEAD_SLOTS, lead);
        write_reg(mlps_pkg::REG_DATA_SLOTS, dat);
        write_reg(mlps_pkg::REG_TAIL_SLOTS, tail);
        write_reg(mlps_pkg::REG_RESET_SLOTS, gap);
    endtask

    task automatic run_to_idle();
        while (seq_phase != mlps_pkg::PH_IDLE) send_word(mlps_pkg::MODE_TICK, rand_pixel());
    endtask

    task automatic wait_until_drained();
        int n;
        s_axis_tvalid = 1'b0;
        n = 0;
        while (pin_words_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        repeat (2) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    // Timing straight out of reset: one lane, RGB, 3/9/4 bit slots, 1000-slot gap;
    // the gap is left running and the next test ends it
    task automatic test_reset_values();
        send_word(MODE_UNUSED, '0);
        send_word(mlps_pkg::MODE_TICK, '0);
        send_word(mlps_pkg::MODE_LOAD,
                  pack_pixel(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_32A5,
                             64'h0F0F_0F0F_0F0F_0F3C, '1, 8'hFF));
        run_to_idle();
        send_word(mlps_pkg::MODE_START, '0);
        repeat (GAP_TICKS) send_word(mlps_pkg::MODE_TICK, '0);
    endtask

    task automatic test_special_cases();
        wait_until_drained();
        // zero slot counts behave as one; inverted pins on all eight lanes
        set_timing(8, 1, 1, 0, 0, 0, 0);
        send_word(mlps_pkg::MODE_TICK, '1);
        send_word(MODE_UNUSED, '1);
        send_word(mlps_pkg::MODE_START, '0);
        send_word(mlps_pkg::MODE_TICK, '0);
        send_word(mlps_pkg::MODE_LOAD, pack_pixel('1, '0, '1, '0, 8'hFF));
        // commands while busy are refused
        send_word(mlps_pkg::MODE_LOAD, pack_pixel('0, '1, '0, '1, 8'h00));
        send_word(mlps_pkg::MODE_START, '1);
        send_word(MODE_UNUSED, '0);
        repeat (6) send_word(mlps_pkg::MODE_TICK, '0);
        wait_until_drained();
        // mid-pixel writes act at once, except four_channel which waits for a load
        write_reg(mlps_pkg::REG_LANE_COUNT, 16'd0);
        write_reg(mlps_pkg::REG_FOUR_CHANNEL, 16'd0);
        write_reg(mlps_pkg::REG_INVERT, 16'd0);
        repeat (6) send_word(mlps_pkg::MODE_TICK, '0);
        wait_until_drained();
        write_reg(mlps_pkg::REG_LANE_COUNT, 16'd12);
        run_to_idle();
        send_word(mlps_pkg::MODE_LOAD, pack_pixel('0, '1, '0, '1, 8'h00));
        run_to_idle();
        send_word(mlps_pkg::MODE_LOAD, pack_pixel('1, '1, '1, '1, 8'hA5));
        run_to_idle();
    endtask

    task automatic test_random_sweep();
        int s;
        int n;
        logic [15:0] lanes;
        for (s = 0; s < SETTINGS_N; s++) begin
            wait_until_drained();
            src_gaps_on    = (s % 3) != 2;
            sink_stalls_on = (s % 4) != 3;
            lanes = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                                : 16'($urandom_range(1, 8));
            case (s)
                0: set_timing(8, 1, 0, 1, 1, 1, 1);
                1: set_timing(1, 0, 1, 2, 3, 1, 4);
                2: set_timing(15, 1, 1, 3, 1, 2, 2);
                default: set_timing(lanes, 16'($urandom_range(0, 1)),
                                    16'($urandom_range(0, 1)),
                                    16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                                    16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)));
            endcase
            for (n = 0; n < SWEEP_WORDS; n++) send_word(pick_mode(), rand_pixel());
        end
    endtask

    // Receiver holds off while ticks keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        int n;
        wait_until_drained();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        set_timing(8, 0, 0, 1, 2, 1, 2);
        send_word(mlps_pkg::MODE_LOAD, rand_pixel());
        stall_requests++;
        for (n = 0; n < 80; n++) send_word(mlps_pkg::MODE_TICK, rand_pixel());
        run_to_idle();
    endtask

    // Largest slot counts and the longest reset gap, without idling; the lengths are cut
    // back after the gap counter passes 255 or the lead part ends, to keep the run short
    task automatic test_timing_extremes();
        wait_until_drained();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        set_timing(15, 1, 1, 255, 255, 255, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h0000);  // no register behind this index
        send_word(mlps_pkg::MODE_START, rand_pixel());
        repeat (EXTREME_TICKS) send_word(mlps_pkg::MODE_TICK, '0);
        wait_until_drained();
        // gap counter is already past the new length: the next tick ends it
        write_reg(mlps_pkg::REG_RESET_SLOTS, 16'd2);
        run_to_idle();
        send_word(mlps_pkg::MODE_LOAD, rand_pixel());
        repeat (EXTREME_TICKS) send_word(mlps_pkg::MODE_TICK, rand_pixel());
        wait_until_drained();
        write_reg(mlps_pkg::REG_LEAD_SLOTS, 16'd1);
        write_reg(mlps_pkg::REG_DATA_SLOTS, 16'd1);
        write_reg(mlps_pkg::REG_TAIL_SLOTS, 16'd1);
        run_to_idle();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin : run_tests
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        clear_serializer();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_special_cases();
        test_random_sweep();
        test_output_backpressure();
        test_timing_extremes();

        wait_until_drained();
        if (pin_words_due.size() != 0) begin
            $display("%0t: outstanding words expected 0 actual %0d",
                     $time, pin_words_due.size());
            errors++;
        end
        $display("Checked %0d words: %0d pixels sent, %0d reset gaps, %0d refused commands.",
                 words_checked, pixels_loaded, gaps_started, refused_cnt);
        $display("Input held off by output backpressure for %0d cycles.", input_stall_cycles);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver ready: random hold-offs plus the long one on request
    initial begin : sink_ready
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0) begin
                if (stall_served != stall_requests) begin
                    stall_served = stall_requests;
                    hold_left = LONG_HOLD;
                end else if (sink_stalls_on && $urandom_range(0, 2) == 0) begin
                    hold_left = idle_len();
                end
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_pin_word w;
        if (i_rst_n) begin
            if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                if (pin_words_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    w = pin_words_due.pop_front();
                    words_checked++;
                    if (m_axis_tdata[7:0] !== w.pins) begin
                        $display("%0t: lane_pins expected %h actual %h",
                                 $time, w.pins, m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[8] !== w.busy) begin
                        $display("%0t: busy_res expected %b actual %b",
                                 $time, w.busy, m_axis_tdata[8]);
                        errors++;
                    end
                    if (m_axis_tdata[9] !== w.rejected) begin
                        $display("%0t: load_rejected expected %b actual %b",
                                 $time, w.rejected, m_axis_tdata[9]);
                        errors++;
                    end
                    if (m_axis_tdata[mlps_pkg::M_TDATA_W-1:10] !== '0) begin
                        $display("%0t: pad expected 0 actual %h",
                                 $time, m_axis_tdata[mlps_pkg::M_TDATA_W-1:10]);
                        errors++;
                    end
                end
            end
        end
    end

    // Run limit
    initial begin : watchdog
        #40ms;
        $display("%0t: run limit reached with %0d words outstanding",
                 $time, pin_words_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
